// File: hw/rtl/fpc_pkg.sv
package fpc_pkg;

  // Register file geometry: eight 64-bit registers, two Q-format entries each
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned ENTRY_W   = 32;
  localparam int unsigned FIELD_W   = 16;

  // One point in
  typedef struct packed {
    logic signed [FIELD_W-1:0] voxel_x;
    logic signed [FIELD_W-1:0] voxel_y;
    logic signed [FIELD_W-1:0] voxel_z;
  } in_item_t;

  // One verdict out, with the point echoed
  typedef struct packed {
    logic                      visible;
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
  } out_item_t;

endpackage

// File: hw/rtl/fpc_row.sv
// One matrix row times (x, y, z, 1): multiply stage, then a sum stage.
module fpc_row import fpc_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic [REG_W-1:0]                     cols01_i,
  input  logic [REG_W-1:0]                     cols23_i,
  input  logic signed [2:0][COORD_BITS-1:0]    coord_i,
  output logic signed [ENTRY_W+COORD_BITS+1:0] clip_o
);

  localparam int unsigned PROD_W = ENTRY_W + COORD_BITS;
  localparam int unsigned ACC_W  = PROD_W + 2;

  logic signed [ENTRY_W-1:0] ent0, ent1, ent2;
  logic signed [PROD_W-1:0]  prod_d [3];
  logic signed [PROD_W-1:0]  prod_q [3];
  logic signed [ENTRY_W-1:0] bias_q;
  logic signed [ACC_W-1:0]   clip_d, clip_q;

  assign ent0 = $signed(cols01_i[ENTRY_W-1:0]);
  assign ent1 = $signed(cols01_i[REG_W-1:ENTRY_W]);
  assign ent2 = $signed(cols23_i[ENTRY_W-1:0]);

  // Products are exact at PROD_W bits
  always_comb begin
    prod_d[0] = PROD_W'(ent0) * PROD_W'($signed(coord_i[0]));
    prod_d[1] = PROD_W'(ent1) * PROD_W'($signed(coord_i[1]));
    prod_d[2] = PROD_W'(ent2) * PROD_W'($signed(coord_i[2]));
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    bias_q <= $signed(cols23_i[REG_W-1:ENTRY_W]);
  end

  // Four-term sum, two guard bits
  assign clip_d = ACC_W'(bias_q) + ACC_W'(prod_q[0]) + ACC_W'(prod_q[1])
                + ACC_W'(prod_q[2]);

  always_ff @(posedge clk_i) begin
    clip_q <= clip_d;
  end

  assign clip_o = clip_q;

endmodule

// File: hw/rtl/frustum_point_cull_top.sv
// Clip-space frustum test of integer points against a 4x4 fixed-point matrix.
// Throughput: one point per clock; the pipeline never stalls, so busy stays low.
// Stages: input register, 12 multipliers, row sums, range compare into the output register.
// Reset: asynchronous, active low; clears valid bits and loads the identity matrix.
module frustum_point_cull_top import fpc_pkg::*; #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned RAW_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int unsigned ACC_W = ENTRY_W + COORD_BITS + 2;
  localparam int unsigned CMP_W = ACC_W + 1;

  logic [REG_W-1:0] regs_q [NUM_REGS];

  logic accept;
  logic v1_q, v2_q, v3_q;
  logic out_valid_q;
  out_item_t out_item_d, out_item_q;
  in_item_t echo1_q, echo2_q, echo3_q;
  logic signed [2:0][COORD_BITS-1:0] coord_d, coord_q;
  logic [RAW_W-1:0] raw_x, raw_y, raw_z;
  logic signed [ACC_W-1:0] clip [4];
  logic signed [CMP_W-1:0] w_ext;
  logic [2:0] in_range;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers, identity after reset
  // Register i holds row i/2; the diagonal entry sits in it when its half matches row/2,
  // in the low word for even rows and the high word for odd rows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[REG_IDX_W'(i)] <= ((i & 1) == ((i >> 1) >> 1))
                               ? ((REG_W'(1) << FRAC_BITS) << (ENTRY_W * ((i >> 1) & 1)))
                               : '0;
      end
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Coordinate = low COORD_BITS of the zero-extended field, sign-extended
  assign raw_x = RAW_W'($unsigned(in_item_i.voxel_x));
  assign raw_y = RAW_W'($unsigned(in_item_i.voxel_y));
  assign raw_z = RAW_W'($unsigned(in_item_i.voxel_z));
  always_comb begin
    coord_d[0] = raw_x[COORD_BITS-1:0];
    coord_d[1] = raw_y[COORD_BITS-1:0];
    coord_d[2] = raw_z[COORD_BITS-1:0];
  end

  // Valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // Payload pipeline: coordinates and echo
  always_ff @(posedge clk_i) begin
    if (accept) begin
      coord_q <= coord_d;
      echo1_q <= in_item_i;
    end
    echo2_q    <= echo1_q;
    echo3_q    <= echo2_q;
    out_item_q <= out_item_d;
  end

  // One row unit per clip component
  for (genvar r = 0; r < 4; r++) begin : g_row
    fpc_row #(
      .COORD_BITS(COORD_BITS)
    ) u_row (
      .clk_i   (clk_i),
      .cols01_i(regs_q[2 * r]),
      .cols23_i(regs_q[2 * r + 1]),
      .coord_i (coord_q),
      .clip_o  (clip[r])
    );
  end

  // -w <= c <= w for x, y, z
  assign w_ext = CMP_W'(clip[3]);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_range[k] = ((CMP_W'(clip[k]) + w_ext) >= 0) && (CMP_W'(clip[k]) <= w_ext);
    end
  end

  always_comb begin
    out_item_d.visible = &in_range;
    out_item_d.out_x   = echo3_q.voxel_x;
    out_item_d.out_y   = echo3_q.voxel_y;
    out_item_d.out_z   = echo3_q.voxel_z;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Every result follows an accepted point
  a_result_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept, 4))
    else $error("result without a matching accepted point");

  // Echoed x and z stay aligned with their verdict
  a_echo_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.out_x == $past(in_item_i.voxel_x, 4)) &&
                    (out_item_o.out_z == $past(in_item_i.voxel_z, 4)))
    else $error("echoed coordinates out of step with the pipeline");

  // Accepted points always come out
  a_accept_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 out_valid_o)
    else $error("accepted point lost in the pipeline");

endmodule

// File: tb/frustum_cull_checker.sv
module frustum_cull_checker import fpc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  in_item_t             point_i,
  input  logic                 result_valid_i,
  input  out_item_t            result_i,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REG_W-1:0] UNIT = REG_W'(1) << FRAC_BITS;

  // Shadow of the matrix registers
  logic [REG_W-1:0] mat_regs [NUM_REGS];
  // Verdicts predicted for accepted points, oldest first
  out_item_t        verdict_q [$];
  out_item_t        want;
  int unsigned      mismatch_count;

  // Signed Q-format entry (r, c) of the shadow matrix
  function automatic longint mat_entry(int r, int c);
    logic [REG_W-1:0]          word;
    logic signed [ENTRY_W-1:0] e;
    word = mat_regs[r * 2 + c / 2];
    e    = (c % 2 == 1) ? word[63:32] : word[31:0];
    return e;
  endfunction

  // Clip-space transform and the -w..w range test, all exact in 64 bits
  function automatic out_item_t predict_cull(in_item_t pt);
    longint    px, py, pz;
    longint    clip [4];
    out_item_t res;
    px = longint'(pt.voxel_x);
    py = longint'(pt.voxel_y);
    pz = longint'(pt.voxel_z);
    for (int r = 0; r < 4; r++) begin
      clip[r] = mat_entry(r, 3) + mat_entry(r, 0) * px + mat_entry(r, 1) * py
              + mat_entry(r, 2) * pz;
    end
    res.visible = 1'b1;
    for (int r = 0; r < 3; r++) begin
      if (clip[r] < -clip[3] || clip[r] > clip[3]) res.visible = 1'b0;
    end
    res.out_x = pt.voxel_x;
    res.out_y = pt.voxel_y;
    res.out_z = pt.voxel_z;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdict_q.delete();
      mismatch_count = 0;
      // identity after reset
      mat_regs[0] <= UNIT;
      mat_regs[1] <= '0;
      mat_regs[2] <= UNIT << 32;
      mat_regs[3] <= '0;
      mat_regs[4] <= '0;
      mat_regs[5] <= UNIT;
      mat_regs[6] <= '0;
      mat_regs[7] <= UNIT << 32;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result transfer: compare with the oldest prediction
      if (result_valid_i) begin
        if (verdict_q.size() == 0) begin
          $error("result with no point outstanding: %p", result_i);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          if (result_i.visible !== want.visible) begin
            $error("visible: expected %0d, got %0d", want.visible, result_i.visible);
            mismatch_count++;
          end
          if (result_i.out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", want.out_x, result_i.out_x);
            mismatch_count++;
          end
          if (result_i.out_y !== want.out_y) begin
            $error("out_y: expected %0d, got %0d", want.out_y, result_i.out_y);
            mismatch_count++;
          end
          if (result_i.out_z !== want.out_z) begin
            $error("out_z: expected %0d, got %0d", want.out_z, result_i.out_z);
            mismatch_count++;
          end
        end
      end
      // point transfer: append at the tail
      if (start_i && !busy_i) verdict_q.insert(verdict_q.size(), predict_cull(point_i));
      // register write takes effect after this edge
      if (cfg_we_i) mat_regs[cfg_idx_i] <= cfg_wdata_i;
      fail_count_o <= mismatch_count;
      pending_o    <= verdict_q.size();
    end
  end

endmodule

// File: tb/tb.sv
module tb import fpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned PHASES         = 12;
  localparam int unsigned POINTS_PER_PH  = 75;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [ENTRY_W-1:0] UNIT    = ENTRY_W'(1) << FRAC_BITS;

  typedef enum int {MAT_ONES, MAT_ZERO, MAT_RANDOM, MAT_EXTREME, MAT_CAMERA} mat_kind_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  in_item_t             point;
  logic                 verdict_valid;
  out_item_t            verdict;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0]     cfg_wdata;
  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          quiet_cycles = 0;

  logic [REG_W-1:0]     matrix_regs [NUM_REGS];
  int unsigned          idle_pct [4] = '{0, 62, 0, 13};

  frustum_point_cull_top #(
    .COORD_BITS(16),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_item_i  (point),
    .out_valid_o(verdict_valid),
    .out_item_o (verdict),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  frustum_cull_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .point_i       (point),
    .result_valid_i(verdict_valid),
    .result_i      (verdict),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: cycles with no transfer of any kind
  always @(posedge clk_i) begin
    if ((start && !busy) || verdict_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("frustum_point_cull_top test failed");
      $finish;
    end
  end

  function automatic logic [ENTRY_W-1:0] rand_signed(int unsigned mag);
    return ENTRY_W'($urandom_range(2 * mag) - mag);
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_extreme();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      default: return UNIT;
    endcase
  endfunction

  // Fill matrix_regs with one matrix of the given flavor
  task automatic build_matrix(mat_kind_e kind);
    logic [ENTRY_W-1:0] ent [4][4];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        case (kind)
          MAT_ONES:    ent[r][c] = '1;
          MAT_ZERO:    ent[r][c] = '0;
          MAT_RANDOM:  ent[r][c] = $urandom;
          MAT_EXTREME: ent[r][c] = rand_extreme();
          default: begin
            // view-projection-like: strong diagonal, small skew, w mostly positive
            if (r == 3) begin
              ent[r][c] = (c == 3) ? ENTRY_W'($urandom_range(1 << 24, 1 << 20))
                                   : rand_signed((c == 2) ? (1 << 12) : (1 << 10));
            end else if (c == 3) begin
              ent[r][c] = rand_signed(1 << 22);
            end else if (c == r) begin
              ent[r][c] = ENTRY_W'($urandom_range(1 << 16, 1 << 12));
              if ($urandom_range(1) == 1) ent[r][c] = -ent[r][c];
            end else begin
              ent[r][c] = rand_signed(1 << 12);
            end
          end
        endcase
      end
    end
    for (int r = 0; r < 4; r++) begin
      matrix_regs[2 * r]     = {ent[r][1], ent[r][0]};
      matrix_regs[2 * r + 1] = {ent[r][3], ent[r][2]};
    end
  endtask

  // Write all eight registers on consecutive edges
  task automatic load_matrix();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= REG_IDX_W'(i);
      cfg_wdata <= matrix_regs[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Present one point and hold it until the transfer
  task automatic send_point(input logic [FIELD_W-1:0] x, y, z);
    in_item_t pt;
    pt.voxel_x = x;
    pt.voxel_y = y;
    pt.voxel_z = z;
    start <= 1'b1;
    point <= pt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop sending and wait until every verdict is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni    <= 1'b0;
    start     <= 1'b0;
    point     <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity after reset: inside iff every coordinate is within -1..1
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h0001, 16'h0001, 16'h0001);
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_point(16'h0002, 16'h0000, 16'h0000);
    send_point(16'h0000, 16'hFFFE, 16'h0000);
    send_point(16'h0000, 16'h0000, 16'h0002);
    send_point(16'h0001, 16'hFFFF, 16'h0000);
    send_point(16'h7FFF, 16'h8000, 16'h0000);
    send_point(16'h8000, 16'h7FFF, 16'h8000);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(16'h5555, 16'hAAAA, 16'h5555);
    send_point(16'hAAAA, 16'h5555, 16'hAAAA);
    send_point(16'hFFFF, 16'h0000, 16'h0001);
    drain();

    // Negative w: nothing passes
    for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = '0;
    matrix_regs[0] = REG_W'(UNIT);
    matrix_regs[2] = {UNIT, 32'h0};
    matrix_regs[5] = REG_W'(UNIT);
    matrix_regs[7] = {-UNIT, 32'h0};
    load_matrix();
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h0001, 16'h0001, 16'h0001);
    send_point(16'h8000, 16'h8000, 16'h8000);
    drain();

    // Zero w: only the origin passes
    matrix_regs[7] = '0;
    load_matrix();
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h0001, 16'h0000, 16'h0000);
    send_point(16'h0000, 16'hFFFF, 16'h0000);
    send_point(16'h0000, 16'h0000, 16'h7FFF);
    drain();

    // Random phases, each with a freshly built matrix and the idle rate idle_pct[p % 4]
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       build_matrix(MAT_ONES);
        1:       build_matrix(MAT_ZERO);
        default: build_matrix(($urandom_range(3) == 0) ? MAT_RANDOM :
                              ($urandom_range(2) == 0) ? MAT_EXTREME : MAT_CAMERA);
      endcase
      load_matrix();
      for (int n = 0; n < POINTS_PER_PH; n++) begin
        if ($urandom_range(99) < 75) begin
          send_point(FIELD_W'(rand_signed(256)), FIELD_W'(rand_signed(256)),
                     FIELD_W'(rand_signed(256)));
        end else begin
          send_point(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
        end
        // sender gaps carry junk on the bus
        while ($urandom_range(99) < idle_pct[p % 4]) begin
          start <= 1'b0;
          point <= {FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom)};
          @(posedge clk_i);
        end
      end
      drain();
    end

    // pipeline tail: catch any stray verdict
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("frustum_point_cull_top test passed");
    end else begin
      $display("frustum_point_cull_top test failed");
    end
    $finish;
  end

endmodule
